// File: hdl/lifna_pkg.sv
// ----------------------------------------------------------------------------
// lifna_pkg: shared types and constants of the LIF neuron array
// Field widths, register indexes, reset values and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package lifna_pkg;

    // Array size
    localparam int MAX_NEURONS = 64;
    localparam int IDX_W       = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int ACT_W       = $clog2(MAX_NEURONS + 1);

    // Field widths
    localparam int CNT_W      = 7;
    localparam int LEAK_W     = 16;
    localparam int POT_W      = 24;
    localparam int AMP_W      = 16;
    localparam int CH_W       = 10;
    localparam int CFG_DATA_W = 24;
    localparam int REG_IDX_W  = 2;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Potential limits, Q16.8
    localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

    // Register reset values
    localparam logic [CNT_W-1:0]        RST_NEURONS = 7'd64;
    localparam logic [LEAK_W-1:0]       RST_LEAK    = 16'd0;
    localparam logic signed [POT_W-1:0] RST_THRESH  = 24'sd256;

    // Register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_NEURONS = 2'd0,
        REG_LEAK    = 2'd1,
        REG_THRESH  = 2'd2
    } reg_idx_t;

    // Work handed from front end to back end
    typedef struct packed {
        logic                    tick;
        logic [IDX_W-1:0]        idx;
        logic signed [AMP_W-1:0] amp;
    } cmd_t;

    // Settings seen by the datapath
    typedef struct packed {
        logic [ACT_W-1:0]        act_count;
        logic [LEAK_W-1:0]       leak;
        logic signed [POT_W-1:0] thresh;
    } cfg_t;

    // Clamp the programmed neuron count into 1 .. MAX_NEURONS
    function automatic logic [ACT_W-1:0] active_count(input logic [CNT_W-1:0] n);
        logic [ACT_W-1:0] r;
        if (n == '0)
            r = ACT_W'(1);
        else if (int'(n) > MAX_NEURONS)
            r = ACT_W'(MAX_NEURONS);
        else
            r = ACT_W'(n);
        return r;
    endfunction

endpackage

// File: hdl/lifna_if.sv
// ----------------------------------------------------------------------------
// lifna_if: channel interfaces of the LIF neuron array
// Event input, result output and configuration write channels, each a
// valid/ready handshake carrying its word.
// ----------------------------------------------------------------------------
interface lifna_in_if import lifna_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [CH_W-1:0]         channel;
    logic signed [AMP_W-1:0] amplitude;

    modport source (output valid, output mode, output channel, output amplitude,
                    input ready);
    modport sink   (input valid, input mode, input channel, input amplitude,
                    output ready);
endinterface

interface lifna_out_if import lifna_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        neuron_index;
    logic                    fired;
    logic signed [POT_W-1:0] new_potential;
    logic                    last;

    modport source (output valid, output neuron_index, output fired,
                    output new_potential, output last, input ready);
    modport sink   (input valid, input neuron_index, input fired,
                    input new_potential, input last, output ready);
endinterface

interface lifna_cfg_if import lifna_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/lifna_ram.sv
// ----------------------------------------------------------------------------
// lifna_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lifna_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/lifna_front.sv
// ----------------------------------------------------------------------------
// lifna_front: event intake and classification
// Accepts event words, maps spike channels onto a neuron with a bit-serial
// remainder unit and hands commands to the back end.
// ----------------------------------------------------------------------------
module lifna_front import lifna_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    lifna_in_if.sink         events,
    input  logic [ACT_W-1:0] act_count,
    output cmd_t             cmd,
    output logic             cmd_valid,
    input  logic             cmd_ready
);

    localparam int REM_W  = ACT_W + 1;
    localparam int STEP_W = $clog2(CH_W + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  rem_shift;
    logic [STEP_W-1:0] step_reg, step_next;
    cmd_t              cmd_reg, cmd_next;

    // Sequence intake, remainder steps and hand-off
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        rem_shift  = {rem_reg[REM_W-2:0], ch_reg[CH_W-1]};

        case (state_reg)
            F_IDLE:
            begin
                if (events.valid)
                begin
                    if (events.mode)
                    begin
                        cmd_next.tick = 1'b1;
                        cmd_next.idx  = '0;
                        cmd_next.amp  = '0;
                        state_next    = F_PUSH;
                    end
                    else
                    begin
                        cmd_next.tick = 1'b0;
                        cmd_next.amp  = events.amplitude;
                        ch_next       = events.channel;
                        rem_next      = '0;
                        step_next     = STEP_W'(CH_W);
                        state_next    = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                // One channel bit per cycle, restoring remainder
                ch_next = {ch_reg[CH_W-2:0], 1'b0};
                if (rem_shift >= REM_W'(act_count))
                    rem_next = rem_shift - REM_W'(act_count);
                else
                    rem_next = rem_shift;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    cmd_next.idx = rem_next[IDX_W-1:0];
                    state_next   = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (cmd_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        cmd_reg  <= cmd_next;
    end

    assign events.ready = (state_reg == F_IDLE);
    assign cmd_valid    = (state_reg == F_PUSH);
    assign cmd          = cmd_reg;

    // A mapped spike always lands on an active neuron
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd.tick |-> ACT_W'(cmd.idx) < act_count)
        else $error("spike mapped beyond active neurons");

endmodule

// File: hdl/lifna_fifo.sv
// ----------------------------------------------------------------------------
// lifna_fifo: command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lifna_fifo import lifna_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= push_data;
    end

    // A full queue stays full until a word is popped
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == QCNT_W'(QUEUE_DEPTH) && !do_pop |=> count_reg == QCNT_W'(QUEUE_DEPTH))
        else $error("command queue occupancy lost");

endmodule

// File: hdl/lifna_back.sv
// ----------------------------------------------------------------------------
// lifna_back: potential update engine
// Pops commands, integrates spikes into the potential RAM and walks the
// active neurons on a tick, applying leak and fire and issuing results.
// ----------------------------------------------------------------------------
module lifna_back import lifna_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    lifna_out_if.source results
);

    typedef enum logic [2:0] {
        B_IDLE   = 3'b001,
        B_READ   = 3'b010,
        B_MODIFY = 3'b100
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic [IDX_W-1:0]        addr_reg, addr_next;
    logic                    tick_reg, tick_next;
    logic signed [AMP_W-1:0] amp_reg, amp_next;
    logic [MAX_NEURONS-1:0]  written_reg;

    logic                    ram_we;
    logic [POT_W-1:0]        ram_wdata;
    logic [POT_W-1:0]        ram_rdata;

    logic signed [POT_W-1:0] cur;
    logic signed [POT_W:0]   spk_sum;
    logic signed [POT_W-1:0] spk_pot;
    logic signed [POT_W:0]   leak_ext;
    logic signed [POT_W:0]   leak_diff;
    logic signed [POT_W-1:0] leak_pot;
    logic                    fire;
    logic signed [POT_W-1:0] tick_pot;
    logic                    last_hit;
    logic                    out_free;
    logic                    load_out;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;
    logic                    out_fired_reg;
    logic signed [POT_W-1:0] out_pot_reg;
    logic                    out_last_reg;

    lifna_ram #(
        .WIDTH (POT_W),
        .DEPTH (MAX_NEURONS)
    ) u_pot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Potential arithmetic; an entry never written reads as zero
    always_comb
    begin
        cur      = written_reg[addr_reg] ? signed'(ram_rdata) : '0;
        spk_sum  = (POT_W+1)'(cur) + (POT_W+1)'(amp_reg);
        if (spk_sum > (POT_W+1)'(POT_MAX))
            spk_pot = POT_MAX;
        else if (spk_sum < (POT_W+1)'(POT_MIN))
            spk_pot = POT_MIN;
        else
            spk_pot = spk_sum[POT_W-1:0];

        leak_ext  = signed'({{(POT_W+1-LEAK_W){1'b0}}, cfg.leak});
        leak_diff = (POT_W+1)'(cur) - leak_ext;
        if (leak_diff < (POT_W+1)'(POT_MIN))
            leak_pot = POT_MIN;
        else
            leak_pot = leak_diff[POT_W-1:0];
        fire     = (leak_pot > cfg.thresh);
        tick_pot = fire ? '0 : leak_pot;
        last_hit = ((ACT_W'(addr_reg) + ACT_W'(1)) == cfg.act_count);
    end

    assign out_free = !out_valid_reg || results.ready;

    // Sequence command pop, RAM read and write-back
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        tick_next  = tick_reg;
        amp_next   = amp_reg;
        cmd_ready  = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = spk_pot;
        load_out   = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    addr_next  = cmd.tick ? '0 : cmd.idx;
                    tick_next  = cmd.tick;
                    amp_next   = cmd.amp;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_MODIFY;
            end
            B_MODIFY:
            begin
                if (!tick_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = spk_pot;
                    state_next = B_IDLE;
                end
                else if (out_free)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = tick_pot;
                    load_out  = 1'b1;
                    if (last_hit)
                        state_next = B_IDLE;
                    else
                    begin
                        addr_next  = addr_reg + IDX_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold control state, written flags and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
                written_reg[addr_reg] <= 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold working values and the result word
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        tick_reg <= tick_next;
        amp_reg  <= amp_next;
        if (load_out)
        begin
            out_index_reg <= addr_reg;
            out_fired_reg <= fire;
            out_pot_reg   <= tick_pot;
            out_last_reg  <= last_hit;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.neuron_index  = out_index_reg;
    assign results.fired         = out_fired_reg;
    assign results.new_potential = out_pot_reg;
    assign results.last          = out_last_reg;

    // A fired neuron is reported at zero
    a_fired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.fired |-> results.new_potential == '0)
        else $error("fired neuron not reset");

    // Only active neurons are reported
    a_index_active: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ACT_W'(results.neuron_index) < cfg.act_count)
        else $error("result for inactive neuron");

    // A spike completes in one write-back
    a_spike_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_MODIFY && !tick_reg |=> state_reg == B_IDLE)
        else $error("spike update did not complete");

endmodule

// File: hdl/lif_neuron_array.sv
// ----------------------------------------------------------------------------
// lif_neuron_array: leaky integrate-and-fire neuron array
// Configuration registers and the front end, queue and back end of the array.
// ----------------------------------------------------------------------------
// The array holds up to MAX_NEURONS Q16.8 membrane potentials, all zero after
// reset (per-entry written flags, so no clearing pass is needed). A spike word
// (mode 0) adds its Q8.8 amplitude, saturating, to neuron channel modulo the
// active count and gives no result. A tick word (mode 1) leaks every active
// neuron, fires and clears those strictly above the threshold, and gives one
// result per active neuron in index order, the final one marked last. The
// front end takes one word at a time and holds a spike word while the
// bit-serial remainder unit maps its channel, one channel bit per cycle;
// a two-entry queue lets it run ahead of the back end. The back end handles
// a spike in an idle, read and modify state and each neuron of a tick in a
// read and a modify state, the read-then-write sequence on the single
// potential RAM, and holds a tick while an earlier result is not yet taken.
// Write the configuration only while no word is in flight.
module lif_neuron_array import lifna_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lifna_in_if.sink    events,
    lifna_out_if.source results,
    lifna_cfg_if.sink   cfg
);

    logic [CNT_W-1:0]        neurons_reg;
    logic [LEAK_W-1:0]       leak_reg;
    logic signed [POT_W-1:0] thresh_reg;
    cfg_t                    cfg_word;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    assign cfg.ready = 1'b1;

    // Hold configuration registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neurons_reg <= RST_NEURONS;
            leak_reg    <= RST_LEAK;
            thresh_reg  <= RST_THRESH;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_NEURONS: neurons_reg <= cfg.data[CNT_W-1:0];
                REG_LEAK:    leak_reg    <= cfg.data[LEAK_W-1:0];
                REG_THRESH:  thresh_reg  <= signed'(cfg.data[POT_W-1:0]);
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cfg_word.act_count = active_count(neurons_reg);
        cfg_word.leak      = leak_reg;
        cfg_word.thresh    = thresh_reg;
    end

    lifna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .act_count (cfg_word.act_count),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    lifna_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    lifna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_word),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .results   (results)
    );

endmodule

// File: test/lif_neuron_array_tb.sv
// ----------------------------------------------------------------------------
// lif_neuron_array_tb: self-checking bench of the LIF neuron array
// Drives spike and tick words with random gaps and back-pressure. A shadow
// copy of the potentials and registers predicts every tick reading, which is
// then compared field by field with what the array returns. Directed words
// come first; the random words that follow walk the potentials up to both
// saturation limits.
// ----------------------------------------------------------------------------
import lifna_pkg::*;

// One predicted tick reading
typedef struct {
    logic [IDX_W-1:0]        idx;
    logic                    fired;
    logic signed [POT_W-1:0] pot;
    logic                    last;
} reading_t;

class lif_checker;
    int               pot_shadow [MAX_NEURONS];
    logic [CNT_W-1:0] count_reg;
    logic [LEAK_W-1:0] leak_reg;
    logic signed [POT_W-1:0] thresh_reg;
    reading_t         pending_readings [$];
    int               errors;
    int               readings;
    int               fired_seen;

    function new();
        foreach (pot_shadow[i])
            pot_shadow[i] = 0;
        count_reg  = RST_NEURONS;
        leak_reg   = RST_LEAK;
        thresh_reg = RST_THRESH;
        errors     = 0;
        readings   = 0;
        fired_seen = 0;
    endfunction

    function int clip(int v);
        if (v > int'(POT_MAX))
            return int'(POT_MAX);
        if (v < int'(POT_MIN))
            return int'(POT_MIN);
        return v;
    endfunction

    // Programmed count folded into 1 .. MAX_NEURONS
    function int neurons_live();
        int n;
        n = int'(count_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_NEURONS)
            n = MAX_NEURONS;
        return n;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NEURONS: count_reg  = data[CNT_W-1:0];
            REG_LEAK:    leak_reg   = data[LEAK_W-1:0];
            REG_THRESH:  thresh_reg = data[POT_W-1:0];
            default:     ;
        endcase
    endfunction

    // Apply one accepted word to the shadow potentials
    function void note_word(logic m, logic [CH_W-1:0] ch, logic signed [AMP_W-1:0] amp);
        int       n;
        int       sel;
        int       v;
        reading_t r;
        n = neurons_live();
        if (m == 1'b0) begin
            sel = int'(ch) % n;
            pot_shadow[sel] = clip(pot_shadow[sel] + int'(amp));
        end
        else begin
            for (int i = 0; i < n; i++) begin
                v = pot_shadow[i] - int'(leak_reg);
                if (v < int'(POT_MIN))
                    v = int'(POT_MIN);
                r.fired = (v > int'(thresh_reg));
                if (r.fired)
                    v = 0;
                pot_shadow[i] = v;
                r.idx  = IDX_W'(i);
                r.pot  = POT_W'(v);
                r.last = (i == n - 1);
                pending_readings.insert(pending_readings.size(), r);
            end
        end
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // Compare one returned reading with the oldest prediction
    task check_reading(logic [IDX_W-1:0] idx, logic fired, logic signed [POT_W-1:0] pot,
                       logic last);
        reading_t want;
        if (pending_readings.size() == 0) begin
            report($sformatf("reading for neuron %0d with none due", idx));
            return;
        end
        want = pending_readings.pop_front();
        readings++;
        if (fired === 1'b1)
            fired_seen++;
        if (idx !== want.idx)
            report($sformatf("neuron_index %0d, want %0d", idx, want.idx));
        if (fired !== want.fired)
            report($sformatf("neuron %0d fired %b, want %b", want.idx, fired, want.fired));
        if (pot !== want.pot)
            report($sformatf("neuron %0d potential %0d, want %0d", want.idx, pot, want.pot));
        if (last !== want.last)
            report($sformatf("neuron %0d last %b, want %b", want.idx, last, want.last));
    endtask
endclass

module lif_neuron_array_tb;

    localparam logic             MODE_SPIKE   = 1'b0;
    localparam logic             MODE_TICK    = 1'b1;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int               QUIET_CYCLES = 100;
    localparam int               IDLE_LIMIT   = 2000;

    logic clk = 1'b0;
    logic rst_n;

    logic send_calm = 1'b0;
    logic recv_calm = 1'b0;
    int   spikes_sent = 0;
    int   ticks_sent  = 0;
    int   reg_writes  = 0;
    int   idle_cycles = 0;

    lif_checker board = new();

    lifna_in_if  word_bus ();
    lifna_out_if out_bus ();
    lifna_cfg_if reg_bus ();

    lif_neuron_array dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (word_bus),
        .results (out_bus),
        .cfg     (reg_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pick new pacing for both sides; a quarter of the time run flat out
    task automatic shuffle_pace();
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input logic m, input logic [CH_W-1:0] ch,
                             input logic signed [AMP_W-1:0] amp);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            word_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_bus.valid     <= 1'b1;
        word_bus.mode      <= m;
        word_bus.channel   <= ch;
        word_bus.amplitude <= amp;
        @(posedge clk);
        while (!word_bus.ready)
            @(posedge clk);
        board.note_word(m, ch, amp);
        if (m == MODE_TICK)
            ticks_sent++;
        else
            spikes_sent++;
    endtask

    // Drop the word stream, wait for every due reading, then let spikes drain
    task automatic settle();
        word_bus.valid <= 1'b0;
        while (board.pending_readings.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write all three registers and one unmapped index, junk in the unused bits
    task automatic set_regs(input logic [CNT_W-1:0] cnt, input logic [LEAK_W-1:0] leak,
                            input logic signed [POT_W-1:0] thr);
        logic [CFG_DATA_W-1:0] data [4];
        logic [REG_IDX_W-1:0]  slot [4];
        data[0] = CFG_DATA_W'($urandom);
        data[0][CNT_W-1:0] = cnt;
        data[1] = CFG_DATA_W'($urandom);
        data[1][LEAK_W-1:0] = leak;
        data[2] = thr;
        data[3] = CFG_DATA_W'($urandom);
        slot[0] = REG_NEURONS;
        slot[1] = REG_LEAK;
        slot[2] = REG_THRESH;
        slot[3] = REG_SPARE;
        settle();
        for (int k = 0; k < 4; k++)
        begin
            reg_bus.valid <= 1'b1;
            reg_bus.index <= slot[k];
            reg_bus.data  <= data[k];
            @(posedge clk);
            while (!reg_bus.ready)
                @(posedge clk);
            board.write_reg(slot[k], data[k]);
            reg_writes++;
        end
        reg_bus.valid <= 1'b0;
    endtask

    // Random spikes and ticks under one setting, with a full drain halfway
    task automatic mixed_phase(input logic [CNT_W-1:0] cnt, input logic [LEAK_W-1:0] leak,
                               input logic signed [POT_W-1:0] thr, input int words);
        set_regs(cnt, leak, thr);
        shuffle_pace();
        for (int k = 0; k < words; k++)
        begin
            if (k == words / 2)
            begin
                settle();
                shuffle_pace();
            end
            if ($urandom_range(0, 4) == 0)
                send_word(MODE_TICK, CH_W'($urandom), AMP_W'($urandom));
            else
                send_word(MODE_SPIKE, CH_W'($urandom), AMP_W'($urandom));
        end
    endtask

    // Pump neuron 0 past the top of the range, with stray ticks and odd spikes
    task automatic climb_phase();
        logic [CH_W-1:0] ch;
        set_regs(7'd2, '0, POT_MAX);
        shuffle_pace();
        for (int k = 0; k < 265; k++)
        begin
            ch = CH_W'($urandom);
            ch[0] = 1'b0;
            send_word(MODE_SPIKE, ch, AMP_W'($urandom_range(32000, 32767)));
            case ($urandom_range(0, 39))
                0: send_word(MODE_TICK, CH_W'($urandom), AMP_W'($urandom));
                1:
                begin
                    ch = CH_W'($urandom);
                    ch[0] = 1'b1;
                    send_word(MODE_SPIKE, ch, AMP_W'(int'($urandom_range(0, 2000)) - 1000));
                end
                default: ;
            endcase
            if (k == 132)
                shuffle_pace();
        end
        send_word(MODE_TICK, CH_W'($urandom), AMP_W'($urandom));
    endtask

    // Heavy leak and negative spikes drive neuron 1 down to the floor
    task automatic sink_phase();
        logic [CH_W-1:0] ch;
        set_regs(7'd2, 16'hFFFF, POT_MAX);
        shuffle_pace();
        for (int k = 0; k < 128; k++)
        begin
            send_word(MODE_TICK, CH_W'($urandom), AMP_W'($urandom));
            if ($urandom_range(0, 7) == 0)
            begin
                ch = CH_W'($urandom);
                ch[0] = 1'b1;
                send_word(MODE_SPIKE, ch, AMP_W'(-int'($urandom_range(31000, 32768))));
            end
            if (k == 64)
                shuffle_pace();
        end
    endtask

    // Result side: random stalls before each word
    initial
    begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = recv_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid)
                @(posedge clk);
        end
    end

    // Check every reading taken
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            board.check_reading(out_bus.neuron_index, out_bus.fired,
                                out_bus.new_potential, out_bus.last);
    end

    // Stop a hung run: count edges with no word moving on any channel
    always @(posedge clk)
    begin
        if ((word_bus.valid && word_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (reg_bus.valid && reg_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("no progress for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        word_bus.valid     <= 1'b0;
        word_bus.mode      <= MODE_SPIKE;
        word_bus.channel   <= '0;
        word_bus.amplitude <= '0;
        reg_bus.valid      <= 1'b0;
        reg_bus.index      <= REG_NEURONS;
        reg_bus.data       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, modulo wrap, threshold edge
        send_word(MODE_SPIKE, 10'd0, 16'sh7FFF);
        send_word(MODE_SPIKE, 10'h3FF, 16'sh8000);
        send_word(MODE_SPIKE, 10'd64, 16'sd256);
        send_word(MODE_SPIKE, 10'd1, 16'sd256);
        send_word(MODE_SPIKE, 10'd2, 16'sd257);
        send_word(MODE_TICK, 10'h3FF, 16'shFFFF);

        // Zero count acts as one neuron; largest leak, lowest threshold
        set_regs(7'd0, 16'hFFFF, POT_MIN);
        send_word(MODE_SPIKE, 10'h3FF, 16'sd100);
        send_word(MODE_TICK, 10'd0, 16'sd0);

        // Count above the array size clamps; threshold out of reach
        set_regs(7'd127, 16'd1, POT_MAX);
        send_word(MODE_SPIKE, 10'd63, 16'sd1);
        send_word(MODE_TICK, 10'h155, 16'sh5555);

        // Shrink to two neurons, then grow back: the others keep their values
        set_regs(7'd2, 16'h8000, 24'sd0);
        send_word(MODE_SPIKE, 10'h155, 16'sh5555);
        send_word(MODE_SPIKE, 10'h2AA, 16'shAAAA);
        send_word(MODE_TICK, 10'h2AA, 16'shAAAA);
        set_regs(RST_NEURONS, RST_LEAK, RST_THRESH);
        send_word(MODE_TICK, 10'd0, 16'sd0);

        // Random traffic over several settings
        mixed_phase(RST_NEURONS, LEAK_W'($urandom_range(0, 300)),
                    POT_W'($urandom_range(0, 1024)), 10);
        mixed_phase(CNT_W'($urandom), LEAK_W'($urandom_range(0, 2000)),
                    POT_W'(int'($urandom_range(0, 4000)) - 2000), 10);
        mixed_phase(CNT_W'($urandom_range(1, 8)), 16'hFFFF, POT_MIN, 8);
        mixed_phase(7'd127, LEAK_W'($urandom), POT_W'($urandom), 8);
        climb_phase();
        sink_phase();

        // Wind down
        word_bus.valid <= 1'b0;
        while (board.pending_readings.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("covered %0d spike words, %0d tick words, %0d register writes",
                 spikes_sent, ticks_sent, reg_writes);
        $display("checked %0d neuron readings, %0d of them fired, %0d mismatches",
                 board.readings, board.fired_seen, board.errors);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
